@@ rtl/core/tcw_pkg.sv @@
// Shared types and constants for the text console writer core.
// Depends on nothing; used by text_console_writer_core.
`default_nettype none

package tcw_pkg;

  localparam int SCREEN_COLS    = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TERM_COUNT     = 3;
  localparam int CELLS_PER_TERM = SCREEN_ROWS * SCREEN_COLS;
  localparam int STORE_DEPTH    = TERM_COUNT * CELLS_PER_TERM;
  localparam int SCROLL_CELLS   = CELLS_PER_TERM - SCREEN_COLS;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

  // Field widths fixed by the interface
  localparam int TERM_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = CHAR_W + ATTR_W;
  localparam int IDX_W   = 11;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int POS_W   = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    REQ_PUT       = 2'd0,
    REQ_BACKSPACE = 2'd1,
    REQ_CLEAR     = 2'd2,
    REQ_READ      = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    req_kind_t          req_type;
    logic [TERM_W-1:0]  terminal;
    logic [CHAR_W-1:0]  char_code;
    logic [IDX_W-1:0]   cell_index;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  read_char;
    logic [ATTR_W-1:0]  read_attr;
    logic [ROW_W-1:0]   cursor_row;
    logic [COL_W-1:0]   cursor_col;
    logic [POS_W-1:0]   cursor_pos;
    logic               scrolled;
  } out_item_t;

  // Attribute each terminal starts with after reset
  function automatic logic [ATTR_W-1:0] color_reset(input int t);
    case (t)
      0:       color_reset = 8'h0F;
      1:       color_reset = 8'h0E;
      2:       color_reset = 8'h02;
      default: color_reset = 8'h0F;
    endcase
  endfunction

  // First store entry of a terminal
  function automatic logic [ADDR_W-1:0] term_base(input logic [TERM_W-1:0] t);
    term_base = ADDR_W'(t) * ADDR_W'(CELLS_PER_TERM);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/text_console_writer_core.sv @@
// Flow: put char (no scroll), backspace and read cell are registered on accept,
// executed in S_EXEC, then the result is registered, from S_DONE if the output
// stalls; scroll and clear first sweep the terminal's cells one per cycle.
// A request is taken only in S_IDLE, so a new one waits until the last is done.
// Reset: cursors home, colors to defaults, then a pass zeroes all 6000 cells of
// the cell memory with in_ready low; configuration writes are taken throughout.
`default_nettype none

module text_console_writer_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire tcw_pkg::in_item_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output tcw_pkg::out_item_t                    out_data,
  input  wire logic                             cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tcw_pkg::ATTR_W-1:0]       cfg_wdata
);

  tcw_pkg::state_t state, state_next;

  logic [tcw_pkg::ATTR_W-1:0] colors [tcw_pkg::TERM_COUNT];
  logic [tcw_pkg::ROW_W-1:0]  cursor_rows [tcw_pkg::TERM_COUNT];
  logic [tcw_pkg::COL_W-1:0]  cursor_cols [tcw_pkg::TERM_COUNT];

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::STORE_DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rd_data;
  logic                       mem_we, mem_re;
  logic [tcw_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;

  logic [tcw_pkg::CNT_W-1:0]  cnt;

  // request held for execution
  tcw_pkg::req_kind_t         req_q;
  logic [tcw_pkg::TERM_W-1:0] term_q;
  logic [tcw_pkg::CHAR_W-1:0] ch_q;
  logic                       term_ok_q, idx_ok_q;
  logic [tcw_pkg::ADDR_W-1:0] base_q, cur_addr_q;
  logic [tcw_pkg::ATTR_W-1:0] attr_q;
  logic [tcw_pkg::ROW_W-1:0]  row_q;
  logic [tcw_pkg::COL_W-1:0]  col_q;
  logic [tcw_pkg::POS_W-1:0]  cur_pos_q;

  // scroll write stage (writes in the cycle after the read)
  logic                       sc_wr_en;
  logic                       sc_copy;
  logic [tcw_pkg::IDX_W-1:0]  sc_idx;

  tcw_pkg::out_item_t         pend, res;
  logic                       accept, out_free, load_exec, load_done, long_op;

  // accept-side lookups
  logic                       in_term_ok, in_idx_ok;
  logic [tcw_pkg::ROW_W-1:0]  in_row;
  logic [tcw_pkg::COL_W-1:0]  in_col;
  logic [tcw_pkg::POS_W-1:0]  in_pos;
  logic [tcw_pkg::ADDR_W-1:0] in_base;
  logic [tcw_pkg::ATTR_W-1:0] in_attr;

  // execute-side results
  logic                       is_nl, do_scroll;
  logic [tcw_pkg::ROW_W-1:0]  row_n, row_inc;
  logic [tcw_pkg::COL_W-1:0]  col_n, col_inc;
  logic [tcw_pkg::ADDR_W-1:0] bs_addr;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // ---------------- accept-side decode ----------------
  always_comb begin
    in_term_ok = 32'(in_data.terminal) < tcw_pkg::TERM_COUNT;
    in_idx_ok  = 32'(in_data.cell_index) < tcw_pkg::CELLS_PER_TERM;
    in_row     = '0;
    in_col     = '0;
    in_attr    = colors[0];
    if (in_term_ok) begin
      in_row  = cursor_rows[in_data.terminal];
      in_col  = cursor_cols[in_data.terminal];
      in_attr = colors[in_data.terminal];
    end
    in_pos  = tcw_pkg::POS_W'(in_row) * tcw_pkg::POS_W'(tcw_pkg::SCREEN_COLS)
              + tcw_pkg::POS_W'(in_col);
    in_base = tcw_pkg::term_base(in_data.terminal);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q      <= in_data.req_type;
      term_q     <= in_data.terminal;
      ch_q       <= in_data.char_code;
      term_ok_q  <= in_term_ok;
      idx_ok_q   <= in_idx_ok;
      base_q     <= in_base;
      attr_q     <= in_attr;
      row_q      <= in_row;
      col_q      <= in_col;
      cur_pos_q  <= in_pos;
      cur_addr_q <= in_base + tcw_pkg::ADDR_W'(in_pos);
    end
  end

  // ---------------- execute-side cursor math ----------------
  always_comb begin
    is_nl     = (ch_q == tcw_pkg::CH_LF) || (ch_q == tcw_pkg::CH_CR);
    row_inc   = row_q + tcw_pkg::ROW_W'(1);
    col_inc   = col_q + tcw_pkg::COL_W'(1);
    row_n     = row_q;
    col_n     = col_q;
    do_scroll = 1'b0;
    bs_addr   = cur_addr_q - tcw_pkg::ADDR_W'(cur_pos_q != '0);
    if (term_ok_q) begin
      case (req_q)
        tcw_pkg::REQ_PUT: begin
          if (is_nl || 32'(col_inc) >= tcw_pkg::SCREEN_COLS) begin
            row_n = row_inc;
            col_n = '0;
          end else begin
            col_n = col_inc;
          end
          if (32'(row_n) >= tcw_pkg::SCREEN_ROWS) begin
            do_scroll = 1'b1;
            row_n     = tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1);
          end
        end
        tcw_pkg::REQ_BACKSPACE: begin
          if (col_q != '0) begin
            col_n = col_q - tcw_pkg::COL_W'(1);
          end else if (row_q != '0) begin
            row_n = row_q - tcw_pkg::ROW_W'(1);
            col_n = tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS - 1);
          end
        end
        tcw_pkg::REQ_CLEAR: begin
          row_n = '0;
          col_n = '0;
        end
        default: ;
      endcase
    end

    res            = '0;
    if (term_ok_q) begin
      res.cursor_row = row_n;
      res.cursor_col = col_n;
      res.cursor_pos = tcw_pkg::POS_W'(row_n) * tcw_pkg::POS_W'(tcw_pkg::SCREEN_COLS)
                       + tcw_pkg::POS_W'(col_n);
      res.scrolled   = do_scroll;
      if (req_q == tcw_pkg::REQ_READ && idx_ok_q) begin
        res.read_char = rd_data[tcw_pkg::CHAR_W-1:0];
        res.read_attr = rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
      end
    end
    long_op = term_ok_q && (do_scroll || req_q == tcw_pkg::REQ_CLEAR);
  end

  // ---------------- state machine ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::S_INIT: begin
        if (32'(cnt) == tcw_pkg::STORE_DEPTH - 1) state_next = tcw_pkg::S_IDLE;
      end
      tcw_pkg::S_IDLE: begin
        if (in_valid) state_next = tcw_pkg::S_EXEC;
      end
      tcw_pkg::S_EXEC: begin
        if (long_op && do_scroll)  state_next = tcw_pkg::S_SCROLL;
        else if (long_op)          state_next = tcw_pkg::S_CLEAR;
        else if (out_free)         state_next = tcw_pkg::S_IDLE;
        else                       state_next = tcw_pkg::S_DONE;
      end
      tcw_pkg::S_SCROLL, tcw_pkg::S_CLEAR: begin
        if (32'(cnt) == tcw_pkg::CELLS_PER_TERM - 1) state_next = tcw_pkg::S_DONE;
      end
      tcw_pkg::S_DONE: begin
        if (out_free) state_next = tcw_pkg::S_IDLE;
      end
      default: state_next = tcw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == tcw_pkg::S_IDLE);
    load_exec = (state == tcw_pkg::S_EXEC) && !long_op && out_free;
    load_done = (state == tcw_pkg::S_DONE) && out_free;
  end

  // sweep counter: reset pass, scroll and clear
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == tcw_pkg::S_EXEC) begin
      cnt <= '0;
    end else if (state == tcw_pkg::S_INIT || state == tcw_pkg::S_SCROLL ||
                 state == tcw_pkg::S_CLEAR) begin
      cnt <= cnt + tcw_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_wr_en <= 1'b0;
    end else begin
      sc_wr_en <= (state == tcw_pkg::S_SCROLL);
    end
    sc_idx  <= cnt[tcw_pkg::IDX_W-1:0];
    sc_copy <= 32'(cnt) < tcw_pkg::SCROLL_CELLS;
  end

  // ---------------- memory port control ----------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = in_base + tcw_pkg::ADDR_W'(in_data.cell_index);

    if (sc_wr_en) begin
      mem_we    = 1'b1;
      mem_waddr = base_q + tcw_pkg::ADDR_W'(sc_idx);
      mem_wdata = {attr_q, sc_copy ? rd_data[tcw_pkg::CHAR_W-1:0] : tcw_pkg::CH_NUL};
    end else begin
      case (state)
        tcw_pkg::S_INIT: begin
          mem_we    = 1'b1;
          mem_waddr = cnt[tcw_pkg::ADDR_W-1:0];
        end
        tcw_pkg::S_EXEC: begin
          if (term_ok_q && req_q == tcw_pkg::REQ_PUT && !is_nl) begin
            mem_we    = 1'b1;
            mem_waddr = cur_addr_q;
            mem_wdata = {attr_q, ch_q};
          end else if (term_ok_q && req_q == tcw_pkg::REQ_BACKSPACE) begin
            mem_we    = 1'b1;
            mem_waddr = bs_addr;
            mem_wdata = {attr_q, tcw_pkg::CH_SPACE};
          end
        end
        tcw_pkg::S_CLEAR: begin
          mem_we    = 1'b1;
          mem_waddr = base_q + tcw_pkg::ADDR_W'(cnt[tcw_pkg::IDX_W-1:0]);
          mem_wdata = {attr_q, tcw_pkg::CH_SPACE};
        end
        default: ;
      endcase
    end

    if (state == tcw_pkg::S_SCROLL) begin
      mem_re    = 32'(cnt) < tcw_pkg::SCROLL_CELLS;
      mem_raddr = base_q + tcw_pkg::ADDR_W'(cnt[tcw_pkg::IDX_W-1:0])
                  + tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_COLS);
    end else begin
      mem_re    = accept && in_term_ok && in_idx_ok &&
                  in_data.req_type == tcw_pkg::REQ_READ;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // ---------------- cursors and colors ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < tcw_pkg::TERM_COUNT; t++) begin
        cursor_rows[t] <= '0;
        cursor_cols[t] <= '0;
      end
    end else if (state == tcw_pkg::S_EXEC && term_ok_q) begin
      cursor_rows[term_q] <= row_n;
      cursor_cols[term_q] <= col_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < tcw_pkg::TERM_COUNT; t++) begin
        colors[t] <= tcw_pkg::color_reset(t);
      end
    end else if (cfg_we && 32'(cfg_index) < tcw_pkg::TERM_COUNT) begin
      colors[cfg_index] <= cfg_wdata;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (state == tcw_pkg::S_EXEC) begin
      pend <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_exec || load_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_exec) begin
      out_data <= res;
    end else if (load_done) begin
      out_data <= pend;
    end
  end

`ifndef SYNTH
  a_no_result_in_init: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::S_INIT) |-> !out_valid)
    else $error("result presented during memory clearing pass");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == tcw_pkg::S_EXEC) |->
      (32'(row_n) < tcw_pkg::SCREEN_ROWS && 32'(col_n) < tcw_pkg::SCREEN_COLS))
    else $error("cursor left the screen");

  a_scroll_drained: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sc_wr_en)
    else $error("new transaction taken while scroll write pending");

  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(mem_waddr) < tcw_pkg::STORE_DEPTH))
    else $error("cell write outside the store");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |->
      ($past(state) == tcw_pkg::S_EXEC || $past(state) == tcw_pkg::S_DONE))
    else $error("result loaded outside execute or done");
`endif

endmodule

`default_nettype wire
